>>> hw/rtl/srp_pkg.sv
package srp_pkg;

  // range check modes of a relocation type
  typedef enum logic [1:0] {
    CHK_NONE = 2'd0,
    CHK_BITS = 2'd1,
    CHK_SIGN = 2'd2,
    CHK_UNSG = 2'd3
  } chk_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNSUP    = 3'd1,
    ST_UNDEF    = 3'd2,
    ST_MISALIGN = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  // relocation type codes that get special handling
  localparam logic [7:0] RTYPE_NONE = 8'd0;

  // supported relocation type codes, standard sparc numbering
  localparam logic [7:0] RT_8       = 8'd1;
  localparam logic [7:0] RT_16      = 8'd2;
  localparam logic [7:0] RT_32      = 8'd3;
  localparam logic [7:0] RT_DISP8   = 8'd4;
  localparam logic [7:0] RT_DISP16  = 8'd5;
  localparam logic [7:0] RT_DISP32  = 8'd6;
  localparam logic [7:0] RT_WDISP30 = 8'd7;
  localparam logic [7:0] RT_WDISP22 = 8'd8;
  localparam logic [7:0] RT_HI22    = 8'd9;
  localparam logic [7:0] RT_22      = 8'd10;
  localparam logic [7:0] RT_13      = 8'd11;
  localparam logic [7:0] RT_LO10    = 8'd12;
  localparam logic [7:0] RT_PC10    = 8'd16;
  localparam logic [7:0] RT_PC22    = 8'd17;
  localparam logic [7:0] RT_UA32    = 8'd23;
  localparam logic [7:0] RT_10      = 8'd30;
  localparam logic [7:0] RT_11      = 8'd31;
  localparam logic [7:0] RT_7       = 8'd43;
  localparam logic [7:0] RT_5       = 8'd44;
  localparam logic [7:0] RT_6       = 8'd45;
  localparam logic [7:0] RT_UA16    = 8'd55;

  // internal arithmetic width: symbol + addend - pc never leaves 36 signed bits
  localparam int unsigned ValW = 36;

  // fixed per-type descriptor; nbytes of zero marks an unsupported type
  typedef struct packed {
    logic [2:0] nbytes;
    logic [5:0] width;
    logic [3:0] shift;
    chk_e       check;
    logic       pcrel;
    logic       unal;
  } desc_t;

  typedef struct packed {
    logic [7:0]         reloc_type;
    logic               symbol_undefined;
    logic [31:0]        symbol_value;
    logic signed [31:0] addend;
    logic [31:0]        section_address;
    logic [31:0]        offset;
    logic [31:0]        old_word;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  patch_bytes;
    logic [31:0] patch_address;
    logic [31:0] new_word;
  } res_t;

  function automatic desc_t mk_desc(input logic [2:0] nb, input logic [5:0] w,
                                    input logic [3:0] sh, input chk_e chk,
                                    input logic pc, input logic ua);
    desc_t d;
    d.nbytes = nb;
    d.width  = w;
    d.shift  = sh;
    d.check  = chk;
    d.pcrel  = pc;
    d.unal   = ua;
    return d;
  endfunction

  // descriptor lookup, standard sparc numbering
  function automatic desc_t lookup_desc(input logic [7:0] rtype);
    desc_t d;
    case (rtype)
      RT_8:       d = mk_desc(3'd1, 6'd8,  4'd0,  CHK_BITS, 1'b0, 1'b0);
      RT_16:      d = mk_desc(3'd2, 6'd16, 4'd0,  CHK_BITS, 1'b0, 1'b0);
      RT_32:      d = mk_desc(3'd4, 6'd32, 4'd0,  CHK_BITS, 1'b0, 1'b0);
      RT_DISP8:   d = mk_desc(3'd1, 6'd8,  4'd0,  CHK_SIGN, 1'b1, 1'b0);
      RT_DISP16:  d = mk_desc(3'd2, 6'd16, 4'd0,  CHK_SIGN, 1'b1, 1'b0);
      RT_DISP32:  d = mk_desc(3'd4, 6'd32, 4'd0,  CHK_SIGN, 1'b1, 1'b0);
      RT_WDISP30: d = mk_desc(3'd4, 6'd30, 4'd2,  CHK_SIGN, 1'b1, 1'b0);
      RT_WDISP22: d = mk_desc(3'd4, 6'd22, 4'd2,  CHK_SIGN, 1'b1, 1'b0);
      RT_HI22:    d = mk_desc(3'd4, 6'd22, 4'd10, CHK_NONE, 1'b0, 1'b0);
      RT_22:      d = mk_desc(3'd4, 6'd22, 4'd0,  CHK_BITS, 1'b0, 1'b0);
      RT_13:      d = mk_desc(3'd4, 6'd13, 4'd0,  CHK_BITS, 1'b0, 1'b0);
      RT_LO10:    d = mk_desc(3'd4, 6'd10, 4'd0,  CHK_NONE, 1'b0, 1'b0);
      RT_PC10:    d = mk_desc(3'd4, 6'd10, 4'd0,  CHK_NONE, 1'b1, 1'b0);
      RT_PC22:    d = mk_desc(3'd4, 6'd22, 4'd10, CHK_BITS, 1'b1, 1'b0);
      RT_UA32:    d = mk_desc(3'd4, 6'd32, 4'd0,  CHK_BITS, 1'b0, 1'b1);
      RT_10:      d = mk_desc(3'd4, 6'd10, 4'd0,  CHK_BITS, 1'b0, 1'b0);
      RT_11:      d = mk_desc(3'd4, 6'd11, 4'd0,  CHK_BITS, 1'b0, 1'b0);
      RT_7:       d = mk_desc(3'd4, 6'd7,  4'd0,  CHK_BITS, 1'b0, 1'b0);
      RT_5:       d = mk_desc(3'd4, 6'd5,  4'd0,  CHK_BITS, 1'b0, 1'b0);
      RT_6:       d = mk_desc(3'd4, 6'd6,  4'd0,  CHK_BITS, 1'b0, 1'b0);
      RT_UA16:    d = mk_desc(3'd2, 6'd16, 4'd0,  CHK_BITS, 1'b0, 1'b1);
      default:    d = mk_desc(3'd0, 6'd0,  4'd0,  CHK_NONE, 1'b0, 1'b0);
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/srp_in_if.sv
interface srp_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         reloc_type;
  logic               symbol_undefined;
  logic [31:0]        symbol_value;
  logic signed [31:0] addend;
  logic [31:0]        section_address;
  logic [31:0]        offset;
  logic [31:0]        old_word;

  modport source (
    output valid, reloc_type, symbol_undefined, symbol_value, addend,
           section_address, offset, old_word,
    input  ready
  );
  modport sink (
    input  valid, reloc_type, symbol_undefined, symbol_value, addend,
           section_address, offset, old_word,
    output ready
  );
endinterface

>>> hw/rtl/srp_out_if.sv
interface srp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  patch_bytes;
  logic [31:0] patch_address;
  logic [31:0] new_word;

  modport source (
    output valid, status, patch_bytes, patch_address, new_word,
    input  ready
  );
  modport sink (
    input  valid, status, patch_bytes, patch_address, new_word,
    output ready
  );
endinterface

>>> hw/rtl/srp_core.sv
module srp_core import srp_pkg::*; (
  input  in_item_t item_i,
  output res_t     res_o
);

  desc_t                  desc;
  logic [31:0]            pc;
  logic signed [ValW-1:0] sym_s;
  logic signed [ValW-1:0] add_s;
  logic signed [ValW-1:0] pc_s;
  logic signed [ValW-1:0] sum;
  logic signed [ValW-1:0] shifted;
  logic [ValW-1:0]        sh_u;
  logic [5:0]             sbits;
  logic [ValW-1:0]        hi_mask;
  logic [ValW-1:0]        umask;
  logic [32:0]            fmask_w;
  logic [31:0]            fmask;
  logic [31:0]            sizemask;
  logic                   fits_signed;
  logic                   fits_unsigned;
  logic                   in_range;
  logic                   misaligned;
  logic [31:0]            merged;

  // descriptor and patch location
  assign desc = lookup_desc(item_i.reloc_type);
  assign pc   = item_i.section_address + item_i.offset;

  // exact value: symbol + addend, minus pc when pc-relative, then arithmetic shift
  assign sym_s   = $signed({4'b0000, item_i.symbol_value});
  assign add_s   = $signed({{4{item_i.addend[31]}}, item_i.addend});
  assign pc_s    = desc.pcrel ? $signed({4'b0000, pc}) : '0;
  assign sum     = sym_s + add_s - pc_s;
  assign shifted = sum >>> desc.shift;
  assign sh_u    = shifted;

  // range check: bits mode allows one more bit than signed mode
  assign sbits         = (desc.check == CHK_BITS) ? desc.width + 6'd1 : desc.width;
  assign hi_mask       = ~((ValW'(1) << (sbits - 6'd1)) - ValW'(1));
  assign fits_signed   = ((sh_u & hi_mask) == '0) || ((sh_u & hi_mask) == hi_mask);
  assign umask         = ~((ValW'(1) << desc.width) - ValW'(1));
  assign fits_unsigned = (sh_u & umask) == '0;

  always_comb begin
    case (desc.check)
      CHK_NONE: in_range = 1'b1;
      CHK_UNSG: in_range = fits_unsigned;
      default:  in_range = fits_signed;
    endcase
  end

  // field and patch size masks
  assign fmask_w = (33'd1 << desc.width) - 33'd1;
  assign fmask   = fmask_w[31:0];

  always_comb begin
    case (desc.nbytes)
      3'd1:    sizemask = 32'h0000_00ff;
      3'd2:    sizemask = 32'h0000_ffff;
      default: sizemask = 32'hffff_ffff;
    endcase
  end

  assign misaligned = !desc.unal && ((pc[2:0] & (desc.nbytes - 3'd1)) != 3'd0);
  assign merged     = ((item_i.old_word & ~fmask) | (sh_u[31:0] & fmask)) & sizemask;

  // status in priority order
  always_comb begin
    res_o.patch_address = pc;
    res_o.patch_bytes   = 3'd0;
    res_o.new_word      = item_i.old_word;
    if (item_i.reloc_type == RTYPE_NONE) begin
      res_o.status = ST_OK;
    end else if (desc.nbytes == 3'd0) begin
      res_o.status = ST_UNSUP;
    end else if (item_i.symbol_undefined) begin
      res_o.status = ST_UNDEF;
    end else if (misaligned) begin
      res_o.status = ST_MISALIGN;
    end else if (!in_range) begin
      res_o.status = ST_OVERFLOW;
    end else begin
      res_o.status      = ST_OK;
      res_o.patch_bytes = desc.nbytes;
      res_o.new_word    = merged;
    end
  end

endmodule

>>> hw/rtl/sparc_elf_relocation_patcher.sv
// SPARC ELF relocation patcher. Each input item is one relocation; each gives
// exactly one result item with status, bytes to write, patch address and the
// patched word. The block is a two-register pipeline: the input register
// feeds the descriptor lookup, add, shift, range check and merge, whose result
// lands in the output register. One item per cycle is sustained while results
// are taken; a result is presented once its item moves from the input register
// to the output register. While a result waits, one more item is taken into
// the input register, then the input stalls until the result goes.
module sparc_elf_relocation_patcher import srp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  srp_in_if.sink    in_i,
  srp_out_if.source out_o
);

  in_item_t in_q;
  logic     in_vld_q;
  logic     in_vld_d;
  res_t     res_q;
  res_t     res_d;
  logic     out_vld_q;
  logic     out_vld_d;
  logic     adv_out;
  logic     in_acc;
  in_item_t in_d;

  // handshake: each stage moves when the one ahead is empty or draining
  assign adv_out    = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || adv_out;
  assign in_acc     = in_i.valid && in_i.ready;

  assign in_d.reloc_type       = in_i.reloc_type;
  assign in_d.symbol_undefined = in_i.symbol_undefined;
  assign in_d.symbol_value     = in_i.symbol_value;
  assign in_d.addend           = in_i.addend;
  assign in_d.section_address  = in_i.section_address;
  assign in_d.offset           = in_i.offset;
  assign in_d.old_word         = in_i.old_word;

  assign in_vld_d  = in_i.ready ? in_i.valid : in_vld_q;
  assign out_vld_d = adv_out ? in_vld_q : out_vld_q;

  // relocation arithmetic
  srp_core u_core (
    .item_i (in_q),
    .res_o  (res_d)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_d;
    end
    if (adv_out && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = res_q.status;
  assign out_o.patch_bytes   = res_q.patch_bytes;
  assign out_o.patch_address = res_q.patch_address;
  assign out_o.new_word      = res_q.new_word;

  // an accepted item is held in the input register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> in_vld_q)
    else $error("accepted item not captured");

  // an item leaving the input register shows up at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && adv_out |=> out_vld_q &&
      res_q.patch_address == $past(in_q.section_address + in_q.offset))
    else $error("item lost or patch address wrong");

  // only a clean result writes bytes, and only 1, 2 or 4 of them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.patch_bytes == 3'd0) ||
      ((res_q.status == ST_OK) && (res_q.patch_bytes == 3'd1 ||
        res_q.patch_bytes == 3'd2 || res_q.patch_bytes == 3'd4)))
    else $error("bad patch byte count");

endmodule

>>> test/sparc_elf_relocation_patcher_tb.sv
module sparc_elf_relocation_patcher_tb import srp_pkg::*; ();

  // type codes used only for stimulus
  localparam logic [7:0] RT_GOT10   = 8'd13;
  localparam logic [7:0] RT_COUNT   = 8'd56;
  localparam logic [7:0] RT_MAX     = 8'hff;

  localparam longint ADD_MIN = -64'sd2147483648;
  localparam longint ADD_MAX = 64'sd2147483647;
  localparam longint SYM_MAX = 64'sd4294967295;

  localparam int RANDOM_ITEMS = 1100;
  localparam int IDLE_PCT     = 17;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  srp_in_if  in_if ();
  srp_out_if out_if ();

  sparc_elf_relocation_patcher uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // patched words still owed by the block, oldest first
  res_t     patch_q[$];
  int       n_acc = 0;
  int       n_mismatch = 0;

  // directed items, some with the result typed in
  in_item_t dir_item[$];
  logic     dir_known[$];
  res_t     dir_res[$];

  // clock and reset
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // descriptor of each relocation type
  function automatic desc_t reloc_desc(input logic [7:0] rtype);
    case (rtype)
      RT_8:       return '{3'd1, 6'd8,  4'd0,  CHK_BITS, 1'b0, 1'b0};
      RT_16:      return '{3'd2, 6'd16, 4'd0,  CHK_BITS, 1'b0, 1'b0};
      RT_32:      return '{3'd4, 6'd32, 4'd0,  CHK_BITS, 1'b0, 1'b0};
      RT_DISP8:   return '{3'd1, 6'd8,  4'd0,  CHK_SIGN, 1'b1, 1'b0};
      RT_DISP16:  return '{3'd2, 6'd16, 4'd0,  CHK_SIGN, 1'b1, 1'b0};
      RT_DISP32:  return '{3'd4, 6'd32, 4'd0,  CHK_SIGN, 1'b1, 1'b0};
      RT_WDISP30: return '{3'd4, 6'd30, 4'd2,  CHK_SIGN, 1'b1, 1'b0};
      RT_WDISP22: return '{3'd4, 6'd22, 4'd2,  CHK_SIGN, 1'b1, 1'b0};
      RT_HI22:    return '{3'd4, 6'd22, 4'd10, CHK_NONE, 1'b0, 1'b0};
      RT_22:      return '{3'd4, 6'd22, 4'd0,  CHK_BITS, 1'b0, 1'b0};
      RT_13:      return '{3'd4, 6'd13, 4'd0,  CHK_BITS, 1'b0, 1'b0};
      RT_LO10:    return '{3'd4, 6'd10, 4'd0,  CHK_NONE, 1'b0, 1'b0};
      RT_PC10:    return '{3'd4, 6'd10, 4'd0,  CHK_NONE, 1'b1, 1'b0};
      RT_PC22:    return '{3'd4, 6'd22, 4'd10, CHK_BITS, 1'b1, 1'b0};
      RT_UA32:    return '{3'd4, 6'd32, 4'd0,  CHK_BITS, 1'b0, 1'b1};
      RT_10:      return '{3'd4, 6'd10, 4'd0,  CHK_BITS, 1'b0, 1'b0};
      RT_11:      return '{3'd4, 6'd11, 4'd0,  CHK_BITS, 1'b0, 1'b0};
      RT_7:       return '{3'd4, 6'd7,  4'd0,  CHK_BITS, 1'b0, 1'b0};
      RT_5:       return '{3'd4, 6'd5,  4'd0,  CHK_BITS, 1'b0, 1'b0};
      RT_6:       return '{3'd4, 6'd6,  4'd0,  CHK_BITS, 1'b0, 1'b0};
      RT_UA16:    return '{3'd2, 6'd16, 4'd0,  CHK_BITS, 1'b0, 1'b1};
      default:    return '0;
    endcase
  endfunction

  // allowed value range of a field after the shift
  function automatic void field_range(input desc_t d, output longint lo, output longint hi);
    longint msk;
    msk = (longint'(1) << d.width) - 1;
    case (d.check)
      CHK_BITS: begin
        hi = msk;
        lo = -msk - 1;
      end
      CHK_SIGN: begin
        hi = msk / 2;
        lo = -hi - 1;
      end
      CHK_UNSG: begin
        hi = msk;
        lo = 0;
      end
      default: begin
        hi = 64'sh7fff_ffff_ffff_ffff;
        lo = -hi - 1;
      end
    endcase
  endfunction

  // expected result of one relocation
  function automatic res_t patch_result(input in_item_t it);
    res_t        r;
    desc_t       d;
    longint      val, msk, lo, hi;
    logic [31:0] size_m;
    r.status        = ST_OK;
    r.patch_bytes   = 3'd0;
    r.patch_address = it.section_address + it.offset;
    r.new_word      = it.old_word;
    d = reloc_desc(it.reloc_type);
    if (it.reloc_type == RTYPE_NONE) return r;
    if (d.nbytes == 3'd0) begin
      r.status = ST_UNSUP;
      return r;
    end
    if (it.symbol_undefined) begin
      r.status = ST_UNDEF;
      return r;
    end
    if (!d.unal && (r.patch_address & (32'(d.nbytes) - 32'd1)) != 32'd0) begin
      r.status = ST_MISALIGN;
      return r;
    end
    // exact sum, then arithmetic shift
    val = longint'(it.symbol_value) + longint'($signed(it.addend));
    if (d.pcrel) val -= longint'(r.patch_address);
    val = val >>> d.shift;
    field_range(d, lo, hi);
    if (val < lo || val > hi) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    // merge under the field mask, clip to the patch size
    msk = (longint'(1) << d.width) - 1;
    case (d.nbytes)
      3'd1:    size_m = 32'h0000_00ff;
      3'd2:    size_m = 32'h0000_ffff;
      default: size_m = 32'hffff_ffff;
    endcase
    r.patch_bytes = d.nbytes;
    r.new_word = ((it.old_word & ~msk[31:0]) | (val[31:0] & msk[31:0])) & size_m;
    return r;
  endfunction

  // random relocation: mostly well formed, with the value often at or just past the range edges
  function automatic in_item_t random_reloc();
    in_item_t    it;
    desc_t       d;
    longint      lo, hi, v, tgt, alo, ahi, a;
    logic [31:0] pa;
    int unsigned mode;
    it.reloc_type       = 8'($urandom);
    it.symbol_undefined = 1'($urandom);
    it.symbol_value     = $urandom;
    it.addend           = $urandom;
    it.section_address  = $urandom;
    it.offset           = $urandom;
    it.old_word         = $urandom;
    mode = $urandom_range(99);
    if (mode < 20) return it;
    do begin
      it.reloc_type = 8'($urandom_range(RT_COUNT - 1));
      d = reloc_desc(it.reloc_type);
    end while (d.nbytes == 3'd0);
    it.symbol_undefined = (mode < 26);
    // keep the location aligned except for a few items
    pa = it.section_address + it.offset;
    if (mode >= 32) it.offset -= pa & (32'(d.nbytes) - 32'd1);
    pa = it.section_address + it.offset;
    field_range(d, lo, hi);
    if (d.check == CHK_NONE) begin
      lo = (-(longint'(1) << 31)) >>> d.shift;
      hi = ((longint'(1) << 31) - 1) >>> d.shift;
    end
    case ($urandom_range(9))
      0:       v = lo;
      1:       v = hi;
      2:       v = lo - 1;
      3:       v = hi + 1;
      default: v = lo + longint'({$urandom, $urandom} % $unsigned(hi - lo + 1));
    endcase
    tgt = v * (longint'(1) << d.shift) + longint'($urandom_range((1 << d.shift) - 1));
    if (d.pcrel) tgt += longint'(pa);
    // split the target into symbol and addend where both fit
    ahi = (tgt < ADD_MAX) ? tgt : ADD_MAX;
    alo = (tgt - SYM_MAX > ADD_MIN) ? tgt - SYM_MAX : ADD_MIN;
    if (alo <= ahi) begin
      a = alo + longint'({$urandom, $urandom} % $unsigned(ahi - alo + 1));
      it.addend = a[31:0];
      tgt -= a;
      it.symbol_value = tgt[31:0];
    end
    return it;
  endfunction

  function automatic bit no_idle();
    return n_acc >= 500 && n_acc < 700;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    n_mismatch++;
  endtask

  task automatic add_row(input logic [7:0] rtype, input logic undef,
                         input logic [31:0] sym, input logic signed [31:0] add,
                         input logic [31:0] sect, input logic [31:0] offs,
                         input logic [31:0] old);
    in_item_t it;
    it = '{rtype, undef, sym, add, sect, offs, old};
    dir_item.push_back(it);
    dir_known.push_back(1'b0);
    dir_res.push_back('0);
  endtask

  task automatic add_known(input logic [7:0] rtype, input logic undef,
                           input logic [31:0] sym, input logic signed [31:0] add,
                           input logic [31:0] sect, input logic [31:0] offs,
                           input logic [31:0] old, input status_e st,
                           input logic [2:0] nb, input logic [31:0] word);
    add_row(rtype, undef, sym, add, sect, offs, old);
    dir_known[dir_known.size() - 1] = 1'b1;
    dir_res[dir_res.size() - 1] = '{st, nb, sect + offs, word};
  endtask

  // result side: random stalls, compare against the oldest expectation
  initial begin
    out_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (patch_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_if.new_word, '0);
        end else begin
          res_t want;
          want = patch_q.pop_front();
          if (out_if.status != want.status)
            report_mismatch("status", 32'(out_if.status), 32'(want.status));
          if (out_if.patch_bytes != want.patch_bytes)
            report_mismatch("patch_bytes", 32'(out_if.patch_bytes),
                            32'(want.patch_bytes));
          if (out_if.patch_address != want.patch_address)
            report_mismatch("patch_address", out_if.patch_address, want.patch_address);
          if (out_if.new_word != want.new_word)
            report_mismatch("new_word", out_if.new_word, want.new_word);
        end
      end
      out_if.ready <= no_idle() || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // relocation side: directed table, then random items, then drain
  initial begin
    in_item_t cur;
    logic     cur_known;
    res_t     cur_res;
    int       n_next;
    int       n_total;
    int       drain;

    in_if.valid            <= 1'b0;
    in_if.reloc_type       <= '0;
    in_if.symbol_undefined <= 1'b0;
    in_if.symbol_value     <= '0;
    in_if.addend           <= '0;
    in_if.section_address  <= '0;
    in_if.offset           <= '0;
    in_if.old_word         <= '0;

    // special cases with the result read off directly
    add_known(RTYPE_NONE, 1'b0, 32'h0000_1234, 32'sd0, 32'hffff_fff0, 32'h10,
              32'hffff_ffff, ST_OK, 3'd0, 32'hffff_ffff);
    add_known(RT_MAX, 1'b0, 32'h0, 32'sd0, 32'h100, 32'h0, 32'h1357_9bdf,
              ST_UNSUP, 3'd0, 32'h1357_9bdf);
    add_known(RT_GOT10, 1'b0, 32'h40, 32'sd0, 32'h0, 32'h8, 32'h0,
              ST_UNSUP, 3'd0, 32'h0);
    add_known(RT_32, 1'b1, 32'h1000, 32'sd0, 32'h2000, 32'h0, 32'hdead_beef,
              ST_UNDEF, 3'd0, 32'hdead_beef);
    add_known(RT_16, 1'b0, 32'h0, 32'sd0, 32'h0, 32'h1, 32'h0000_ffff,
              ST_MISALIGN, 3'd0, 32'h0000_ffff);
    add_known(RT_8, 1'b0, 32'h100, 32'sd0, 32'h0, 32'h0, 32'h12,
              ST_OVERFLOW, 3'd0, 32'h12);
    // each supported type, several at their range edges
    add_row(RT_8,       1'b0, 32'h0,         -32'sd256,        32'h0,       32'h0, 32'hffff_ffff);
    add_row(RT_16,      1'b0, 32'h0000_ffff, 32'sd0,           32'h0,       32'h2, 32'h1234_5678);
    add_row(RT_32,      1'b0, 32'hffff_ffff, 32'sd0,           32'h0,       32'h4, 32'h0);
    add_row(RT_DISP8,   1'b0, 32'h107f,      32'sd0,           32'h1000,    32'h0, 32'ha5);
    add_row(RT_DISP16,  1'b0, 32'h0,         -32'sd28672,      32'h1000,    32'h0, 32'h5a5a);
    add_row(RT_DISP32,  1'b0, 32'h0,         32'sh8000_0000,   32'h0,       32'h0, 32'ha5a5_5a5a);
    add_row(RT_WDISP30, 1'b0, 32'h4000_0000, 32'sd3,           32'h100,     32'h0, 32'h4000_0000);
    add_row(RT_WDISP22, 1'b0, 32'h007f_fffc, 32'sd0,           32'h0,       32'h0, 32'hffff_ffff);
    add_row(RT_HI22,    1'b0, 32'hffff_ffff, 32'sh7fff_ffff,   32'h0,       32'h0, 32'h0);
    add_row(RT_22,      1'b0, 32'h003f_ffff, 32'sd0,           32'h8,       32'h8, 32'hffc0_0000);
    add_row(RT_13,      1'b0, 32'h0,         -32'sd8192,       32'h0,       32'hc, 32'h8000_1fff);
    add_row(RT_LO10,    1'b0, 32'h1234_5678, 32'sd0,           32'h0,       32'h0, 32'hffff_ffff);
    add_row(RT_PC10,    1'b0, 32'h2000,      32'sd5,           32'h1000,    32'h0, 32'h9000_0000);
    add_row(RT_PC22,    1'b0, 32'h0,         32'sd0,           32'h0001_0000, 32'h4, 32'h0);
    add_row(RT_UA32,    1'b0, 32'hdead_beef, 32'sd0,           32'h0,       32'h3, 32'h0);
    add_row(RT_10,      1'b0, 32'h3ff,       32'sd0,           32'h0,       32'h0, 32'h0);
    add_row(RT_11,      1'b0, 32'h0,         -32'sd2048,       32'h0,       32'h0, 32'hffff_ffff);
    add_row(RT_7,       1'b0, 32'h7f,        32'sd0,           32'h0,       32'h0, 32'h0);
    add_row(RT_5,       1'b0, 32'h1f,        32'sd0,           32'h0,       32'h0, 32'hffff_ffe0);
    add_row(RT_6,       1'b0, 32'h20,        32'sd0,           32'h0,       32'h0, 32'h0);
    add_row(RT_UA16,    1'b0, 32'h0000_ffff, 32'sd0,           32'h0,       32'h1, 32'hffff_ffff);

    n_total   = dir_item.size() + RANDOM_ITEMS;
    n_next    = 0;
    cur_known = 1'b0;
    cur_res   = '0;
    while (!rst_ni) @(posedge clk_i);

    while (n_acc < n_total) begin
      @(posedge clk_i);
      if (in_if.valid && in_if.ready) begin
        patch_q.push_back(cur_known ? cur_res : patch_result(cur));
        n_acc++;
      end
      // hold an item that has not been taken yet
      if (!(in_if.valid && !in_if.ready)) begin
        if (n_next < n_total && (no_idle() || $urandom_range(99) >= IDLE_PCT)) begin
          if (n_next < dir_item.size()) begin
            cur       = dir_item[n_next];
            cur_known = dir_known[n_next];
            cur_res   = dir_res[n_next];
          end else begin
            cur       = random_reloc();
            cur_known = 1'b0;
          end
          n_next++;
          in_if.valid            <= 1'b1;
          in_if.reloc_type       <= cur.reloc_type;
          in_if.symbol_undefined <= cur.symbol_undefined;
          in_if.symbol_value     <= cur.symbol_value;
          in_if.addend           <= cur.addend;
          in_if.section_address  <= cur.section_address;
          in_if.offset           <= cur.offset;
          in_if.old_word         <= cur.old_word;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end

    // wait for the pipeline to empty, then wait on for stray results
    drain = 0;
    while (patch_q.size() != 0 && drain < 2000) begin
      @(posedge clk_i);
      drain++;
    end
    if (patch_q.size() != 0)
      report_mismatch("results never arrived", patch_q.size(), '0);
    repeat (6) @(posedge clk_i);

    if (n_mismatch == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/srp_pkg.sv
hw/rtl/srp_in_if.sv
hw/rtl/srp_out_if.sv
hw/rtl/srp_core.sv
hw/rtl/sparc_elf_relocation_patcher.sv
test/sparc_elf_relocation_patcher_tb.sv
